>>> rtl/cpts_pkg.sv
`default_nettype none
package cpts_pkg;

   // task table geometry
   localparam int TASK_SLOTS = 64;
   localparam int ADDR_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

   typedef logic [ADDR_W-1:0] addr_type;

   // one task table entry
   typedef struct packed {
      logic        present;
      logic [2:0]  run_state;
      logic [7:0]  counter;
      logic [6:0]  priority_val;
      logic [30:0] alarm;
      logic [31:0] pending;
      logic [31:0] blocked;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{
      present: 1'b0, run_state: 3'd0, counter: 8'd0, priority_val: 7'd1,
      alarm: 31'd0, pending: 32'd0, blocked: 32'd0
   };

   // commands
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_SCHED = 2'd2
   } cmd_type;

   // run states the scheduler acts on
   localparam logic [2:0] RS_RUNNING       = 3'd0;
   localparam logic [2:0] RS_INTERRUPTIBLE = 3'd1;

   // signal masks: alarm is signal 14, kill 9 and stop 19 cannot be blocked
   localparam logic [31:0] SIG_ALARM_BIT   = 32'h0000_2000;
   localparam logic [31:0] SIG_UNBLOCKABLE = 32'h0004_0100;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_ALARM,
      S_RECOMP
   } state_type;

endpackage
`default_nettype wire

>>> rtl/cpts_table.sv
`default_nettype none
module cpts_table
   import cpts_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire addr_type  rd_addr,
   output entry_type      rd_data,
   input  wire logic      wr_en,
   input  wire addr_type  wr_addr,
   input  wire entry_type wr_data
);

   entry_type             slots_ff [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] valid_ff;
   entry_type             rd_data_ff;

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
   end

   // valid bits: an entry never written reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read, write-first on the same entry
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else if (valid_ff[rd_addr]) begin
         rd_data_ff <= slots_ff[rd_addr];
      end else begin
         rd_data_ff <= RESET_ENTRY;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/counter_priority_task_scheduler_core.sv
`default_nettype none
// Counter-decay priority task scheduler.
// Request channel (req_valid/req_ready) carries one command per transaction:
// write a task entry, read a task entry, or run a schedule. Every request
// gives exactly one response transaction on rsp_valid/rsp_ready.
// The task table lives in a synchronous RAM with a registered read;
// a schedule streams over tasks 1..TASK_SLOTS-1 one entry per cycle,
// reading, updating and writing back in a two-step pipeline.
// Write and unknown commands respond straight from the idle state; a read
// responds from the read state. A schedule runs an alarm, wake and pick pass,
// and when the best counter is zero a recompute and re-pick pass follows.
// Throughput is one request at a time; the next request is taken in the
// cycle the response is taken, or earlier if the response register is free.
// Reset empties the table at once through per-entry valid bits (all entries
// read as their reset values) and drops any pending response.
// A stalled receiver holds the response register; no new request is
// accepted until it has been taken.
module counter_priority_task_scheduler_core
   import cpts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [5:0]  req_task_index,
   input  wire logic [30:0] req_now_ticks,
   input  wire logic        req_present,
   input  wire logic [2:0]  req_run_state,
   input  wire logic [7:0]  req_counter,
   input  wire logic [6:0]  req_priority_req,
   input  wire logic [30:0] req_alarm_tick,
   input  wire logic [31:0] req_pending_signals,
   input  wire logic [31:0] req_blocked_signals,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_next_task,
   output logic             rsp_out_present,
   output logic [2:0]       rsp_out_run_state,
   output logic [7:0]       rsp_out_counter,
   output logic [6:0]       rsp_out_priority,
   output logic [30:0]      rsp_out_alarm_tick,
   output logic [31:0]      rsp_out_pending_signals
);

   localparam addr_type LAST_K  = ADDR_W'(TASK_SLOTS - 1);
   localparam addr_type FIRST_K = ADDR_W'(1);

   state_type   state_ff, state_in;
   addr_type    iss_k_ff, iss_k_in;
   logic        iss_on_ff, iss_on_in;
   logic        s1_v_ff, s1_v_in;
   addr_type    s1_k_ff, s1_k_in;
   logic [30:0] now_ff, now_in;
   logic        found_ff, found_in;
   logic [7:0]  best_ff, best_in;
   addr_type    pick_ff, pick_in;
   logic        oor_ff, oor_in;

   logic        rsp_valid_ff;
   logic        rsp_load;
   logic [5:0]  rsp_next_task_ff, rsp_next_task_in;
   logic        rsp_present_ff, rsp_present_in;
   logic [2:0]  rsp_run_state_ff, rsp_run_state_in;
   logic [7:0]  rsp_counter_ff, rsp_counter_in;
   logic [6:0]  rsp_priority_ff, rsp_priority_in;
   logic [30:0] rsp_alarm_ff, rsp_alarm_in;
   logic [31:0] rsp_pending_ff, rsp_pending_in;

   addr_type    rd_addr;
   entry_type   rd_data;
   logic        wr_en;
   addr_type    wr_addr;
   entry_type   wr_data;

   logic        req_fire;
   logic        in_range;
   logic        pass_done;
   entry_type   alarm_e;
   entry_type   recomp_e;
   entry_type   mod_e;
   logic [8:0]  recomp_sum;
   logic        cand;

   cpts_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // alarm expiry and wake-up of one entry
   always_comb begin
      alarm_e = rd_data;
      if (rd_data.present) begin
         if ((rd_data.alarm != 31'd0) && (rd_data.alarm < now_ff)) begin
            alarm_e.pending = rd_data.pending | SIG_ALARM_BIT;
            alarm_e.alarm   = 31'd0;
         end
         if (((alarm_e.pending & ~(rd_data.blocked & ~SIG_UNBLOCKABLE)) != 32'd0)
             && (rd_data.run_state == RS_INTERRUPTIBLE)) begin
            alarm_e.run_state = RS_RUNNING;
         end
      end
   end

   // counter decay: half plus priority, saturating
   always_comb begin
      recomp_e   = rd_data;
      recomp_sum = {2'b00, rd_data.counter[7:1]} + {2'b00, rd_data.priority_val};
      if (rd_data.present) begin
         recomp_e.counter = recomp_sum[8] ? 8'hFF : recomp_sum[7:0];
      end
   end

   assign mod_e = (state_ff == S_RECOMP) ? recomp_e : alarm_e;
   assign cand  = mod_e.present && (mod_e.run_state == RS_RUNNING);

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = 32'(req_task_index) < TASK_SLOTS;

   // sequencer
   always_comb begin
      state_in         = state_ff;
      iss_k_in         = iss_k_ff;
      iss_on_in        = iss_on_ff;
      s1_v_in          = 1'b0;
      s1_k_in          = s1_k_ff;
      now_in           = now_ff;
      found_in         = found_ff;
      best_in          = best_ff;
      pick_in          = pick_ff;
      oor_in           = oor_ff;
      rd_addr          = (state_ff == S_IDLE) ? ADDR_W'(req_task_index) : iss_k_ff;
      wr_en            = 1'b0;
      wr_addr          = s1_k_ff;
      wr_data          = mod_e;
      pass_done        = 1'b0;
      rsp_load         = 1'b0;
      rsp_next_task_in = 6'd0;
      rsp_present_in   = 1'b0;
      rsp_run_state_in = 3'd0;
      rsp_counter_in   = 8'd0;
      rsp_priority_in  = 7'd0;
      rsp_alarm_in     = 31'd0;
      rsp_pending_in   = 32'd0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_command)
                  CMD_WRITE: begin
                     wr_en                = in_range;
                     wr_addr              = ADDR_W'(req_task_index);
                     wr_data.present      = req_present;
                     wr_data.run_state    = req_run_state;
                     wr_data.counter      = req_counter;
                     wr_data.priority_val = (req_priority_req == 7'd0) ? 7'd1
                                                                       : req_priority_req;
                     wr_data.alarm        = req_alarm_tick;
                     wr_data.pending      = req_pending_signals;
                     wr_data.blocked      = req_blocked_signals;
                     rsp_load             = 1'b1;
                  end
                  CMD_READ: begin
                     oor_in   = !in_range;
                     state_in = S_READ;
                  end
                  CMD_SCHED: begin
                     now_in    = req_now_ticks;
                     iss_k_in  = FIRST_K;
                     iss_on_in = 1'b1;
                     found_in  = 1'b0;
                     best_in   = 8'd0;
                     pick_in   = '0;
                     state_in  = S_ALARM;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_load = 1'b1;
            if (!oor_ff) begin
               rsp_present_in   = rd_data.present;
               rsp_run_state_in = rd_data.run_state;
               rsp_counter_in   = rd_data.counter;
               rsp_priority_in  = rd_data.priority_val;
               rsp_alarm_in     = rd_data.alarm;
               rsp_pending_in   = rd_data.pending;
            end
            state_in = S_IDLE;
         end
         S_ALARM, S_RECOMP: begin
            // issue side
            s1_v_in = iss_on_ff;
            s1_k_in = iss_k_ff;
            if (iss_on_ff) begin
               if (iss_k_ff == LAST_K) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_k_in = iss_k_ff + FIRST_K;
               end
            end
            // update, write back and pick
            if (s1_v_ff) begin
               wr_en = 1'b1;
               if (cand && (!found_ff || (mod_e.counter >= best_ff))) begin
                  found_in = 1'b1;
                  best_in  = mod_e.counter;
                  pick_in  = s1_k_ff;
               end
               pass_done = (s1_k_ff == LAST_K);
            end
            if (pass_done) begin
               if ((state_ff == S_ALARM) && found_in && (best_in == 8'd0)) begin
                  iss_k_in  = FIRST_K;
                  iss_on_in = 1'b1;
                  s1_v_in   = 1'b0;
                  found_in  = 1'b0;
                  best_in   = 8'd0;
                  pick_in   = '0;
                  state_in  = S_RECOMP;
               end else begin
                  rsp_load         = 1'b1;
                  rsp_next_task_in = 6'(pick_in);
                  state_in         = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_on_ff    <= 1'b0;
         s1_v_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         iss_on_ff <= iss_on_in;
         s1_v_ff   <= s1_v_in;
         found_ff  <= found_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      iss_k_ff <= iss_k_in;
      s1_k_ff  <= s1_k_in;
      now_ff   <= now_in;
      best_ff  <= best_in;
      pick_ff  <= pick_in;
      oor_ff   <= oor_in;
      if (rsp_load) begin
         rsp_next_task_ff <= rsp_next_task_in;
         rsp_present_ff   <= rsp_present_in;
         rsp_run_state_ff <= rsp_run_state_in;
         rsp_counter_ff   <= rsp_counter_in;
         rsp_priority_ff  <= rsp_priority_in;
         rsp_alarm_ff     <= rsp_alarm_in;
         rsp_pending_ff   <= rsp_pending_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_next_task           = rsp_next_task_ff;
   assign rsp_out_present         = rsp_present_ff;
   assign rsp_out_run_state       = rsp_run_state_ff;
   assign rsp_out_counter         = rsp_counter_ff;
   assign rsp_out_priority        = rsp_priority_ff;
   assign rsp_out_alarm_tick      = rsp_alarm_ff;
   assign rsp_out_pending_signals = rsp_pending_ff;

`ifndef SYNTHESIS
   // no new transaction while a command is still in progress
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("request accepted while busy");

   // a recompute pass never leaves a zero best counter
   a_recomp_nonzero: assert property (@(posedge clock) disable iff (reset)
      (pass_done && (state_ff == S_RECOMP)) |-> (!found_in || (best_in != 8'd0)))
      else $error("zero best counter after recompute");

   // pipeline write-back only happens inside a pass
   a_wb_in_pass: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> ((state_ff == S_ALARM) || (state_ff == S_RECOMP)))
      else $error("write-back outside a pass");

   // a response is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (state_ff != S_IDLE)) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");
`endif

endmodule
`default_nettype wire
